/* design/psfca_pkg.sv */
// ----------------------------------------------------------------------------
// psfca_pkg
// Shared codes, constants and the sequencer state type of the point-spread
// containment-angle lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package psfca_pkg;

  // command codes of an input transfer
  localparam logic [1:0] CMD_LOAD_ENERGY  = 2'd0;
  localparam logic [1:0] CMD_LOAD_ANGLE   = 2'd1;
  localparam logic [1:0] CMD_LOAD_DENSITY = 2'd2;
  localparam logic [1:0] CMD_QUERY        = 2'd3;

  // configuration register indexes
  localparam logic REG_ENERGY_COUNT = 1'b0;
  localparam logic REG_ANGLE_COUNT  = 1'b1;

  // fixed-point constants
  localparam logic [30:0]        PI_Q29      = 31'd1686629713;   // pi, Q2.29
  localparam logic signed [37:0] ONE_Q24     = 38'sd16777216;    // probability one
  localparam logic [23:0]        DEG180_Q16  = 24'd11796480;     // 180 degrees
  localparam logic signed [38:0] ACC_CAP     = 39'sd68719476736; // 2^36
  localparam logic [45:0]        TERM_CAP    = 46'd68719476736;  // 2^36
  localparam logic signed [65:0] ROW_CAP     = 66'sd268435456;   // 2^28
  localparam logic signed [65:0] DEG180_WIDE = 66'sd11796480;

  // divider
  localparam int QW = 64;   // dividend / quotient magnitude bits
  localparam int DW = 40;   // divisor bits

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_E0_RD,
    ST_E0_CHK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_EL_RD,
    ST_EU_RD,
    ST_EU_CAP,
    ST_ROW_INIT,
    ST_ROW_LOAD0,
    ST_CHK,
    ST_WALK_RD,
    ST_WALK_CAP,
    ST_MUL_PI,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_TERM,
    ST_ACC,
    ST_ANG_LO_RD,
    ST_ANG_HI_RD,
    ST_ANG_HI_CAP,
    ST_ROW_EVAL,
    ST_ROW_MUL,
    ST_ROW_DSTART,
    ST_ROW_DWAIT,
    ST_E_EVAL,
    ST_E_MUL,
    ST_E_DSTART,
    ST_E_DWAIT,
    ST_FINAL
  } state_t;

endpackage

`default_nettype wire

/* design/psfca_ram.sv */
// ----------------------------------------------------------------------------
// psfca_ram
// Single-port synchronous RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psfca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* design/psfca_div.sv */
// ----------------------------------------------------------------------------
// psfca_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. Operands are sampled on start; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module psfca_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [63:0]   dividend,
  input  wire logic signed [39:0]   divisor,
  output logic                      done,
  output logic signed [64:0]        quotient
);
  import psfca_pkg::*;

  localparam int CW = $clog2(QW);

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [QW-1:0] dq;
  logic [DW-1:0] dvs;
  logic          qneg;
  logic [QW:0]   a_ext;
  logic [DW:0]   b_ext;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    a_ext = dividend[63] ? -{dividend[63], dividend} : {dividend[63], dividend};
    b_ext = divisor[39] ? -{divisor[39], divisor} : {divisor[39], divisor};
    trial = {rem, dq[QW-1]};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(QW - 1));
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == CW'(QW - 1))) begin
        run <= 1'b0;
      end
    end
    if (start) begin
      dq   <= a_ext[QW-1:0];
      dvs  <= b_ext[DW-1:0];
      rem  <= '0;
      cnt  <= '0;
      qneg <= dividend[63] ^ divisor[39];
    end else if (run) begin
      rem <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
      dq  <= {dq[QW-2:0], ge};
      cnt <= cnt + CW'(1);
    end
  end

  assign quotient = qneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

endmodule

`default_nettype wire

/* design/psf_containment_angle_lookup.sv */
// ----------------------------------------------------------------------------
// psf_containment_angle_lookup
// Point-spread containment angle: table loads and energy/probability queries.
// ----------------------------------------------------------------------------
// Loads (commands 0..2) are written in the accepting cycle and may follow
// back to back. They give no result. A query raises busy and returns one
// result on a one-cycle done strobe, which the receiver cannot stall. The
// query runs a binary search of the energy table, then sums ring terms for
// the lower and upper energy rows, at most the clamped angle count minus one
// each. Every ring term costs eight states: the check, one read of the
// single-port cosine and density RAMs, the capture, a chain of three
// multiplies, the term and the accumulate. Up to three divisions run through
// the shared one-bit-per-cycle divider. Tables are not cleared at reset, so
// query only entries that were loaded. Write configuration only while busy
// is low. Counts are sampled when a query is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module psf_containment_angle_lookup #(
  parameter int MAX_ENERGIES = 64,
  parameter int MAX_ANGLES   = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  input  wire logic [1:0]         command,
  input  wire logic [5:0]         energy_row,
  input  wire logic [5:0]         angle_col,
  input  wire logic [31:0]        energy,
  input  wire logic [23:0]        angle_deg,
  input  wire logic signed [31:0] angle_cos,
  input  wire logic [31:0]        density,
  input  wire logic [24:0]        probability,
  output logic [23:0]             containment_angle,
  output logic                    extrapolated,
  output logic                    saturated,
  input  wire logic               wr_en,
  input  wire logic               wr_index,
  input  wire logic [6:0]         wr_data
);
  import psfca_pkg::*;

  localparam int EAW = $clog2(MAX_ENERGIES);
  localparam int AAW = $clog2(MAX_ANGLES);
  localparam int DAW = $clog2(MAX_ENERGIES * MAX_ANGLES);

  state_t state, state_next;

  // configuration
  logic [6:0] energy_count;
  logic [6:0] angle_count;

  // query context
  logic [31:0]     e_q;
  logic [24:0]     p_q;
  logic [EAW-1:0]  ne_m1, ne_m1_next;
  logic [AAW-1:0]  na_m1, na_m1_next;
  logic [EAW-1:0]  lo, hi;
  logic [31:0]     el, eu;
  logic            row_hi;
  logic            hit;

  // ring walk
  logic [AAW-1:0]        i;
  logic signed [37:0]    cur, prev;
  logic [31:0]           c0;
  logic [31:0]           d0;
  logic [32:0]           dsum;
  logic [32:0]           magc;
  logic                  neg;
  logic [63:0]           mp;
  logic [64:0]           pl, ph;
  logic signed [37:0]    term;
  logic [AAW-1:0]        lo_idx;
  logic                  closing;
  logic                  direct;
  logic [23:0]           lowa, upa;
  logic signed [29:0]    sl, su;
  logic signed [63:0]    num;
  logic signed [39:0]    den;
  logic signed [65:0]    rfin;

  // RAM ports
  logic [EAW-1:0] e_addr;
  logic [AAW-1:0] a_addr;
  logic [DAW-1:0] d_addr;
  logic           e_we, a_we, d_we;
  logic [31:0]    e_rd;
  logic [23:0]    a_rd;
  logic [31:0]    c_rd;
  logic [31:0]    d_rd;

  // divider
  logic               div_start;
  logic               div_done;
  logic signed [64:0] quo;

  // combinational helpers
  logic               accept;
  logic [EAW-1:0]     mid;
  logic [EAW-1:0]     srch_lo_n, srch_hi_n;
  logic [EAW-1:0]     row_sel;
  logic               walk_go;
  logic               need_close;
  logic signed [32:0] cdiff;
  logic [96:0]        full;
  logic [45:0]        mag_raw;
  logic [36:0]        mag;
  logic signed [38:0] acc_sum;
  logic signed [24:0] d_ang;
  logic signed [38:0] d_prob;
  logic signed [65:0] row_r;
  logic signed [29:0] row_val;
  logic signed [30:0] d_s;
  logic signed [32:0] d_e;
  logic               in_row, in_col;

  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // table memories
  // --------------------------------------------------------------------------
  psfca_ram #(.WIDTH(32), .DEPTH(MAX_ENERGIES)) u_energy_ram (
    .clk(clk), .we(e_we), .addr(e_addr), .wdata(energy), .rdata(e_rd)
  );

  psfca_ram #(.WIDTH(24), .DEPTH(MAX_ANGLES)) u_angle_ram (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(angle_deg), .rdata(a_rd)
  );

  psfca_ram #(.WIDTH(32), .DEPTH(MAX_ANGLES)) u_cos_ram (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(angle_cos), .rdata(c_rd)
  );

  psfca_ram #(.WIDTH(32), .DEPTH(MAX_ENERGIES * MAX_ANGLES)) u_density_ram (
    .clk(clk), .we(d_we), .addr(d_addr), .wdata(density), .rdata(d_rd)
  );

  psfca_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(num), .divisor(den),
    .done(div_done), .quotient(quo)
  );

  // --------------------------------------------------------------------------
  // datapath helpers
  // --------------------------------------------------------------------------
  always_comb begin
    // counts in use, clamped to 2..MAX
    if (energy_count < 7'd2) begin
      ne_m1_next = EAW'(1);
    end else if (32'(energy_count) > 32'(MAX_ENERGIES)) begin
      ne_m1_next = EAW'(MAX_ENERGIES - 1);
    end else begin
      ne_m1_next = EAW'(energy_count - 7'd1);
    end
    if (angle_count < 7'd2) begin
      na_m1_next = AAW'(1);
    end else if (32'(angle_count) > 32'(MAX_ANGLES)) begin
      na_m1_next = AAW'(MAX_ANGLES - 1);
    end else begin
      na_m1_next = AAW'(angle_count - 7'd1);
    end

    in_row = ({26'd0, energy_row} < 32'(MAX_ENERGIES));
    in_col = ({26'd0, angle_col} < 32'(MAX_ANGLES));

    // binary search probe
    mid = EAW'(({1'b0, lo} + {1'b0, hi}) >> 1);
    if (e_rd > e_q) begin
      srch_lo_n = lo;
      srch_hi_n = mid;
    end else begin
      srch_lo_n = mid;
      srch_hi_n = hi;
    end

    row_sel = row_hi ? hi : lo;

    // keep walking while rings remain and the target is not reached
    walk_go    = (i < na_m1) && (cur < $signed({13'd0, p_q}));
    need_close = (i == na_m1) && (cur < $signed({13'd0, p_q}));

    // ring term pieces
    cdiff   = $signed({c0[31], c0}) - $signed({c_rd[31], c_rd});
    full    = {ph, 32'd0} + {32'd0, pl};
    mag_raw = full[96:51];
    mag     = (mag_raw > TERM_CAP) ? TERM_CAP[36:0] : mag_raw[36:0];
    acc_sum = $signed({cur[37], cur}) + $signed({term[37], term});

    // angle interpolation in probability
    d_ang  = $signed({1'b0, upa}) - $signed({1'b0, lowa});
    d_prob = $signed({14'd0, p_q}) - $signed({prev[37], prev});
    row_r  = $signed({42'd0, lowa}) + $signed({quo[64], quo});
    if (row_r > ROW_CAP) begin
      row_val = 30'(ROW_CAP);
    end else if (row_r < -ROW_CAP) begin
      row_val = 30'(-ROW_CAP);
    end else begin
      row_val = 30'(row_r);
    end

    // energy interpolation
    d_s = $signed({su[29], su}) - $signed({sl[29], sl});
    d_e = $signed({1'b0, e_q}) - $signed({1'b0, el});
  end

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_QUERY)) begin
          state_next = ST_E0_RD;
        end
      end
      ST_E0_RD:  state_next = ST_E0_CHK;
      ST_E0_CHK: begin
        if ((e_q >= e_rd) && (ne_m1 > EAW'(1))) begin
          state_next = ST_SRCH_RD;
        end else begin
          state_next = ST_EL_RD;
        end
      end
      ST_SRCH_RD:  state_next = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if ((srch_hi_n - srch_lo_n) > EAW'(1)) begin
          state_next = ST_SRCH_RD;
        end else begin
          state_next = ST_EL_RD;
        end
      end
      ST_EL_RD:     state_next = ST_EU_RD;
      ST_EU_RD:     state_next = ST_EU_CAP;
      ST_EU_CAP:    state_next = ST_ROW_INIT;
      ST_ROW_INIT:  state_next = ST_ROW_LOAD0;
      ST_ROW_LOAD0: state_next = ST_CHK;
      ST_CHK:       state_next = walk_go ? ST_WALK_RD : ST_ANG_LO_RD;
      ST_WALK_RD:   state_next = ST_WALK_CAP;
      ST_WALK_CAP:  state_next = ST_MUL_PI;
      ST_MUL_PI:    state_next = ST_MUL_LO;
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_TERM;
      ST_TERM:      state_next = ST_ACC;
      ST_ACC:       state_next = ST_CHK;
      ST_ANG_LO_RD: state_next = ST_ANG_HI_RD;
      ST_ANG_HI_RD: state_next = ST_ANG_HI_CAP;
      ST_ANG_HI_CAP: state_next = ST_ROW_EVAL;
      ST_ROW_EVAL: begin
        if (direct || (cur == prev)) begin
          state_next = row_hi ? ST_E_EVAL : ST_ROW_INIT;
        end else begin
          state_next = ST_ROW_MUL;
        end
      end
      ST_ROW_MUL:    state_next = ST_ROW_DSTART;
      ST_ROW_DSTART: state_next = ST_ROW_DWAIT;
      ST_ROW_DWAIT: begin
        if (div_done) begin
          state_next = row_hi ? ST_E_EVAL : ST_ROW_INIT;
        end
      end
      ST_E_EVAL:   state_next = (el == eu) ? ST_FINAL : ST_E_MUL;
      ST_E_MUL:    state_next = ST_E_DSTART;
      ST_E_DSTART: state_next = ST_E_DWAIT;
      ST_E_DWAIT: begin
        if (div_done) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: memory ports and strobes
  // --------------------------------------------------------------------------
  always_comb begin
    busy      = (state != ST_IDLE);
    div_start = 1'b0;
    e_we      = 1'b0;
    a_we      = 1'b0;
    d_we      = 1'b0;
    e_addr    = '0;
    a_addr    = '0;
    d_addr    = DAW'(row_sel) * DAW'(MAX_ANGLES);
    case (state)
      ST_IDLE: begin
        // load path: address straight from the transfer
        e_addr = EAW'(energy_row);
        a_addr = AAW'(angle_col);
        d_addr = DAW'(energy_row) * DAW'(MAX_ANGLES) + DAW'(angle_col);
        e_we   = accept && (command == CMD_LOAD_ENERGY) && in_row;
        a_we   = accept && (command == CMD_LOAD_ANGLE) && in_col;
        d_we   = accept && (command == CMD_LOAD_DENSITY) && in_row && in_col;
      end
      ST_SRCH_RD: e_addr = mid;
      ST_EL_RD:   e_addr = lo;
      ST_EU_RD:   e_addr = hi;
      ST_WALK_RD: begin
        a_addr = i + AAW'(1);
        d_addr = DAW'(row_sel) * DAW'(MAX_ANGLES) + DAW'(i + AAW'(1));
      end
      ST_ANG_LO_RD:  a_addr = lo_idx;
      ST_ANG_HI_RD:  a_addr = i;
      ST_ROW_DSTART: div_start = 1'b1;
      ST_E_DSTART:   div_start = 1'b1;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      energy_count <= 7'd2;
      angle_count  <= 7'd2;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINAL);
      if (wr_en) begin
        case (wr_index)
          REG_ENERGY_COUNT: energy_count <= wr_data;
          REG_ANGLE_COUNT:  angle_count  <= wr_data;
          default: begin
          end
        endcase
      end
    end

    case (state)
      ST_IDLE: begin
        // capture the query
        e_q   <= energy;
        p_q   <= probability;
        ne_m1 <= ne_m1_next;
        na_m1 <= na_m1_next;
        hit   <= 1'b0;
      end
      ST_E0_CHK: begin
        lo <= '0;
        if (e_q >= e_rd) begin
          hi <= ne_m1;
        end else begin
          hi <= EAW'(1);   // below the table: clamp to the first pair
        end
      end
      ST_SRCH_CMP: begin
        lo <= srch_lo_n;
        hi <= srch_hi_n;
      end
      ST_EU_RD: el <= e_rd;
      ST_EU_CAP: begin
        eu     <= e_rd;
        row_hi <= 1'b0;
      end
      ST_ROW_INIT: begin
        i    <= '0;
        cur  <= '0;
        prev <= '0;
      end
      ST_ROW_LOAD0: begin
        c0 <= c_rd;
        d0 <= d_rd;
      end
      ST_CHK: begin
        if (!walk_go) begin
          direct  <= (i == '0);
          closing <= 1'b0;
          if (i == '0) begin
            lo_idx <= '0;
          end else if (need_close) begin
            // past the last grid angle: close at probability one
            prev    <= cur;
            cur     <= ONE_Q24;
            closing <= 1'b1;
            lo_idx  <= i;
          end else begin
            lo_idx <= i - AAW'(1);
          end
        end
      end
      ST_WALK_CAP: begin
        dsum <= {1'b0, d0} + {1'b0, d_rd};
        neg  <= cdiff[32];
        magc <= cdiff[32] ? 33'(-cdiff) : 33'(cdiff);
        c0   <= c_rd;
        d0   <= d_rd;
      end
      ST_MUL_PI: mp <= magc * PI_Q29;
      ST_MUL_LO: pl <= dsum * mp[31:0];
      ST_MUL_HI: ph <= dsum * mp[63:32];
      // a capped ring term is not reported as clipping
      ST_TERM: term <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      ST_ACC: begin
        prev <= cur;
        i    <= i + AAW'(1);
        if (acc_sum > ACC_CAP) begin
          cur <= 38'(ACC_CAP);
          hit <= 1'b1;
        end else if (acc_sum < -ACC_CAP) begin
          cur <= 38'(-ACC_CAP);
          hit <= 1'b1;
        end else begin
          cur <= 38'(acc_sum);
        end
      end
      ST_ANG_HI_RD:  lowa <= a_rd;
      ST_ANG_HI_CAP: upa  <= closing ? DEG180_Q16 : a_rd;
      ST_ROW_EVAL: begin
        if (direct || (cur == prev)) begin
          if (row_hi) begin
            su <= $signed({6'd0, lowa});
          end else begin
            sl <= $signed({6'd0, lowa});
          end
          row_hi <= 1'b1;
        end
      end
      ST_ROW_MUL: begin
        num <= d_ang * d_prob;
        den <= {{2{cur[37]}}, cur} - {{2{prev[37]}}, prev};
      end
      ST_ROW_DWAIT: begin
        if (div_done) begin
          if (row_hi) begin
            su <= row_val;
          end else begin
            sl <= row_val;
          end
          row_hi <= 1'b1;
          if ((row_r > ROW_CAP) || (row_r < -ROW_CAP)) begin
            hit <= 1'b1;
          end
        end
      end
      ST_E_EVAL: rfin <= {{36{sl[29]}}, sl};
      ST_E_MUL: begin
        num <= d_s * d_e;
        den <= {{7{1'b0}}, eu} - {{7{1'b0}}, el};
      end
      ST_E_DWAIT: begin
        if (div_done) begin
          rfin <= $signed({{36{sl[29]}}, sl}) + $signed({quo[64], quo});
        end
      end
      ST_FINAL: begin
        // saturate to 0..180 degrees and present the result
        extrapolated <= (e_q < el) || (e_q > eu);
        if (rfin < 0) begin
          containment_angle <= '0;
          saturated         <= 1'b1;
        end else if (rfin > DEG180_WIDE) begin
          containment_angle <= DEG180_Q16;
          saturated         <= 1'b1;
        end else begin
          containment_angle <= rfin[23:0];
          saturated         <= hit;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/psfca_chk.sv */
// ----------------------------------------------------------------------------
// psfca_chk
// Port-level checks of the containment-angle lookup, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psfca_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  command,
  input wire logic [23:0] containment_angle
);
  import psfca_pkg::*;

  // a result transfer closes the query: the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // exactly one cycle per result
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a query holds the block and never answers in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == CMD_QUERY)) |=> (busy && !done))
    else $error("query did not start");

  // a load gives no result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command != CMD_QUERY)) |=> !done)
    else $error("result after a load");

  // results stay within 0..180 degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (containment_angle <= DEG180_Q16))
    else $error("containment angle above 180 degrees");

endmodule

bind psf_containment_angle_lookup psfca_chk u_psfca_chk (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .command(command),
  .containment_angle(containment_angle)
);

`default_nettype wire
